### hdl/hcbp_pkg.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared constants, function codes, controller states and the command and
// status bundles that join the controller to the datapath.
// -----------------------------------------------------------------------------
package hcbp_pkg;

	// Sizing of the code table and of the codes it holds.
	localparam int MAX_CODE_BITS = 32;
	localparam int SYMBOL_COUNT  = 256;
	localparam int BYTE_BITS     = 8;
	localparam int CODE_BITS     = 32;
	localparam int LEN_BITS      = 6;
	localparam int SYM_BITS      = 8;
	localparam int FUNC_BITS     = 2;
	localparam int PEND_BITS     = BYTE_BITS - 1;
	localparam int CNT_BITS      = 3;
	localparam int ACC_BITS      = PEND_BITS + CODE_BITS;
	localparam int TOT_BITS      = 6;
	localparam int ADDR_BITS     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	// Longest code length that a table entry keeps.
	localparam int LEN_LIMIT_INT = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
	localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(LEN_LIMIT_INT);

	// Function codes of an input transaction.
	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2
	} func_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic mem_write;
		logic mem_read;
		logic load_code;
		logic load_flush;
		logic emit;
		logic finish;
	} hcbp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sym_ok;
		logic cnt_nz;
		logic total_ge8;
		logic last_byte;
		logic out_free;
	} hcbp_sts_t;

endpackage

### hdl/hcbp_item_if.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer input channel
// Valid/ready channel that carries one load, encode or flush request.
// -----------------------------------------------------------------------------
interface hcbp_item_if;
	import hcbp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FUNC_BITS-1:0] func;
	logic [SYM_BITS-1:0]  symbol;
	logic [CODE_BITS-1:0] code_value;
	logic [LEN_BITS-1:0]  code_length;

	modport source (output valid, output func, output symbol, output code_value,
		output code_length, input ready);
	modport sink (input valid, input func, input symbol, input code_value,
		input code_length, output ready);
endinterface

### hdl/hcbp_result_if.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer output channel
// Valid/ready channel that carries one packed byte and its last marker.
// -----------------------------------------------------------------------------
interface hcbp_result_if;
	import hcbp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [BYTE_BITS-1:0] packed_byte;
	logic                 last;

	modport source (output valid, output packed_byte, output last, input ready);
	modport sink (input valid, input packed_byte, input last, output ready);
endinterface

### hdl/hcbp_datapath.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer datapath
// Code table memory, bit accumulator, pending bit buffer and the output
// register, all driven by commands from the controller.
// -----------------------------------------------------------------------------
module hcbp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hcbp_pkg::hcbp_cmd_t            cmd,
	output hcbp_pkg::hcbp_sts_t            sts,
	input  logic [hcbp_pkg::SYM_BITS-1:0]  symbol,
	input  logic [hcbp_pkg::CODE_BITS-1:0] code_value,
	input  logic [hcbp_pkg::LEN_BITS-1:0]  code_length,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [hcbp_pkg::BYTE_BITS-1:0] packed_byte,
	output logic                           last
);
	import hcbp_pkg::*;

	localparam int ENTRY_BITS = LEN_BITS + CODE_BITS;

	logic [ENTRY_BITS-1:0] table_mem [SYMBOL_COUNT];
	logic [ENTRY_BITS-1:0] rd_q;
	logic [ADDR_BITS-1:0]  addr;
	logic [LEN_BITS-1:0]   ld_len;
	logic [CODE_BITS:0]    ld_mask;
	logic [CODE_BITS-1:0]  ld_code;
	logic [LEN_BITS-1:0]   rd_len;
	logic [CODE_BITS-1:0]  rd_code;

	logic [ACC_BITS-1:0]   acc_q;
	logic [TOT_BITS-1:0]   total_q;
	logic [ACC_BITS-1:0]   acc_code;
	logic [TOT_BITS-1:0]   total_code;
	logic [ACC_BITS-1:0]   acc_flush;
	logic [TOT_BITS-1:0]   rem;
	logic [TOT_BITS-1:0]   keep_tot;
	logic [CNT_BITS-1:0]   keep_cnt;
	logic [BYTE_BITS-1:0]  keep_mask8;
	logic [BYTE_BITS-1:0]  emit_byte;

	logic [PEND_BITS-1:0]  buf_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  out_valid_q;
	logic [BYTE_BITS-1:0]  byte_q;
	logic                  last_q;

	// Table address and the clamped, masked entry written by a load.
	assign addr    = symbol[ADDR_BITS-1:0];
	assign ld_len  = (code_length > LEN_LIMIT) ? LEN_LIMIT : code_length;
	assign ld_mask = ((CODE_BITS+1)'(1) << ld_len) - (CODE_BITS+1)'(1);
	assign ld_code = code_value & ld_mask[CODE_BITS-1:0];

	// Code table with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_write) begin
			table_mem[addr] <= {ld_len, ld_code};
		end
		if (cmd.mem_read) begin
			rd_q <= table_mem[addr];
		end
	end

	assign rd_len  = rd_q[ENTRY_BITS-1 -: LEN_BITS];
	assign rd_code = rd_q[CODE_BITS-1:0];

	// Accumulator contents for an encode and for a flush.
	assign acc_code   = (ACC_BITS'(buf_q) << rd_len) | ACC_BITS'(rd_code);
	assign total_code = TOT_BITS'(cnt_q) + rd_len;
	assign acc_flush  = ACC_BITS'(buf_q) << (4'(BYTE_BITS) - {1'b0, cnt_q});

	// Byte extraction from the top of the valid accumulator bits.
	assign rem       = total_q - TOT_BITS'(BYTE_BITS);
	assign emit_byte = BYTE_BITS'(acc_q >> rem);

	// Bits left pending when the transaction finishes.
	assign keep_tot   = cmd.emit ? rem : total_q;
	assign keep_cnt   = keep_tot[CNT_BITS-1:0];
	assign keep_mask8 = (BYTE_BITS'(1) << keep_cnt) - BYTE_BITS'(1);

	// Accumulator and remaining bit count.
	always_ff @(posedge clk) begin
		if (cmd.load_code) begin
			acc_q   <= acc_code;
			total_q <= total_code;
		end else if (cmd.load_flush) begin
			acc_q   <= acc_flush;
			total_q <= TOT_BITS'(BYTE_BITS);
		end else if (cmd.emit) begin
			total_q <= rem;
		end
	end

	// Pending bit buffer, kept between transactions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (cmd.finish) begin
			buf_q <= acc_q[PEND_BITS-1:0] & keep_mask8[PEND_BITS-1:0];
			cnt_q <= keep_cnt;
		end
	end

	// Output register: holds one byte until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= emit_byte;
			last_q <= sts.last_byte;
		end
	end

	// Status toward the controller.
	assign sts.sym_ok    = ({1'b0, symbol} < (SYM_BITS+1)'(SYMBOL_COUNT));
	assign sts.cnt_nz    = (cnt_q != '0);
	assign sts.total_ge8 = (total_q >= TOT_BITS'(BYTE_BITS));
	assign sts.last_byte = (rem < TOT_BITS'(BYTE_BITS));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign packed_byte = byte_q;
	assign last        = last_q;
endmodule

### hdl/hcbp_controller.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer controller
// State machine that accepts transactions, sequences the table read and
// steps out one byte per cycle while the output register is free.
// -----------------------------------------------------------------------------
module hcbp_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [hcbp_pkg::FUNC_BITS-1:0] func,
	output logic                           in_ready,
	input  hcbp_pkg::hcbp_sts_t            sts,
	output hcbp_pkg::hcbp_cmd_t            cmd
);
	import hcbp_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   accept;

	assign accept = in_valid && in_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_ENCODE && sts.sym_ok) begin
						state_n = ST_READ;
					end else if (func == FUNC_FLUSH && sts.cnt_nz) begin
						state_n = ST_EMIT;
					end
				end
			end
			ST_READ: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.total_ge8) begin
					state_n = ST_IDLE;
				end else if (sts.out_free && sts.last_byte) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.mem_write  = (func == FUNC_LOAD) && sts.sym_ok;
					cmd.mem_read   = (func == FUNC_ENCODE) && sts.sym_ok;
					cmd.load_flush = (func == FUNC_FLUSH) && sts.cnt_nz;
				end
			end
			ST_READ: begin
				cmd.load_code = 1'b1;
			end
			ST_EMIT: begin
				if (!sts.total_ge8) begin
					cmd.finish = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.finish = sts.last_byte;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

### hdl/huffman_code_bit_packer.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer
// Loads a 256-entry code table and packs the codes of encoded bytes into an
// MSB-first byte stream, with a flush that zero-pads the last partial byte.
// -----------------------------------------------------------------------------
// A load completes in the cycle it is accepted. An encode reads the code table
// (one registered memory read) and then steps out its packed bytes; a flush with
// pending bits emits the zero-padded byte, and one with none completes when
// accepted. The byte rate is one per cycle while the sink takes each byte, set by
// the single output register. The next transaction is accepted as soon as the last
// byte of the current one is in the output register, even if the sink has not yet
// taken it. The last output is high on the final byte of each transaction.
// The table has no reset: encode only symbols whose entries were loaded.
// -----------------------------------------------------------------------------
module huffman_code_bit_packer (
	input  logic            clk,
	input  logic            arst_n,
	hcbp_item_if.sink       item,
	hcbp_result_if.source   result
);
	import hcbp_pkg::*;

	hcbp_cmd_t cmd;
	hcbp_sts_t sts;

	// Sequencing of each transaction.
	hcbp_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.func     (item.func),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, bit packing and output register.
	hcbp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.symbol      (item.symbol),
		.code_value  (item.code_value),
		.code_length (item.code_length),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.packed_byte (result.packed_byte),
		.last        (result.last)
	);
endmodule

### hdl/hcbp_checker.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer checker
// Port-level checks on handshake behavior, attached to the top level by bind.
// -----------------------------------------------------------------------------
module hcbp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [hcbp_pkg::FUNC_BITS-1:0] in_func,
	input logic [hcbp_pkg::SYM_BITS-1:0]  in_symbol,
	input logic                           out_valid,
	input logic                           out_ready
);
	import hcbp_pkg::*;

	logic in_acc;
	logic sym_ok;

	assign in_acc = in_valid && in_ready;
	assign sym_ok = ({1'b0, in_symbol} < (SYM_BITS+1)'(SYMBOL_COUNT));

	// A pending byte stays offered until the sink takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output byte withdrawn before it was taken");

	// An encode of a table symbol always goes through the table read first.
	a_encode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_func == FUNC_ENCODE && sym_ok |=> !in_ready)
		else $error("input ready right after an encode was accepted");

	// A load completes in its own cycle.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_func == FUNC_LOAD |=> in_ready)
		else $error("input not ready after a load");

	// A load never produces a byte.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_func == FUNC_LOAD && !out_valid |=> !out_valid)
		else $error("byte appeared after a load");
endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_func   (item.func),
	.in_symbol (item.symbol),
	.out_valid (result.valid),
	.out_ready (result.ready)
);

### test/huffman_code_bit_packer_tb.sv
// -----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Loads code table entries, encodes bytes and flushes partial bytes through the
// input channel, predicts every packed byte and its last marker in step with
// each accepted transaction, and checks the output channel in order while both
// sides idle and stall at varying rates.
// -----------------------------------------------------------------------------
module huffman_code_bit_packer_tb;
	import hcbp_pkg::*;

	// Function code that the block ignores.
	localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
	// Cycles without any transaction before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Cycles allowed after the last expected byte for stray output.
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 96;

	typedef struct {
		logic [FUNC_BITS-1:0] func;
		logic [SYM_BITS-1:0]  symbol;
		logic [CODE_BITS-1:0] code_value;
		logic [LEN_BITS-1:0]  code_length;
	} packer_item_t;

	typedef struct {
		logic [BYTE_BITS-1:0] packed_byte;
		logic                 last;
	} packed_out_t;

	logic clk;
	logic arst_n;

	hcbp_item_if   item_ch();
	hcbp_result_if byte_ch();

	huffman_code_bit_packer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (byte_ch)
	);

	// Stimulus and expectation stores.
	packer_item_t pending_items[$];
	packed_out_t  expected_bytes[$];

	// Predicted code table and bit buffer.
	logic [CODE_BITS-1:0] code_bits_tbl [SYMBOL_COUNT];
	logic [LEN_BITS-1:0]  code_len_tbl  [SYMBOL_COUNT];
	logic [PEND_BITS-1:0] pend_bits;
	logic [CNT_BITS-1:0]  pend_cnt;

	// Entries loaded so far, as seen by the stimulus generator.
	bit              gen_loaded [SYMBOL_COUNT];
	logic [7:0]      gen_syms[$];

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int load_count;
	int encode_count;
	int flush_count;
	int checked_bytes;
	logic item_taken;
	int quiet_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] low_mask(input int unsigned n);
		return (64'd1 << n) - 64'd1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	// Works out the packed bytes that one accepted transaction gives.
	task automatic predict_packed_bytes(input packer_item_t it);
		logic [ACC_BITS-1:0] acc;
		int unsigned len;
		int unsigned total;
		packed_out_t res;
		case (it.func)
			FUNC_LOAD: begin
				len = (it.code_length > LEN_LIMIT_INT) ? LEN_LIMIT_INT : it.code_length;
				code_len_tbl[it.symbol] = LEN_BITS'(len);
				code_bits_tbl[it.symbol] = it.code_value & CODE_BITS'(low_mask(len));
				load_count++;
			end
			FUNC_ENCODE: begin
				encode_count++;
				len = code_len_tbl[it.symbol];
				if (len != 0) begin
					acc = (ACC_BITS'(pend_bits) << len) | ACC_BITS'(code_bits_tbl[it.symbol]);
					total = pend_cnt + len;
					while (total >= BYTE_BITS) begin
						total -= BYTE_BITS;
						res.packed_byte = BYTE_BITS'(acc >> total);
						res.last = (total < BYTE_BITS);
						expected_bytes.push_back(res);
					end
					pend_bits = PEND_BITS'(acc & ACC_BITS'(low_mask(total)));
					pend_cnt = CNT_BITS'(total);
				end
			end
			FUNC_FLUSH: begin
				flush_count++;
				if (pend_cnt != 0) begin
					res.packed_byte = {1'b0, pend_bits} << (BYTE_BITS - pend_cnt);
					res.last = 1'b1;
					expected_bytes.push_back(res);
					pend_bits = '0;
					pend_cnt = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_item(input logic [FUNC_BITS-1:0] func, input logic [7:0] sym,
			input logic [31:0] value, input logic [5:0] len);
		packer_item_t it;
		it.func = func;
		it.symbol = sym;
		it.code_value = value;
		it.code_length = len;
		pending_items.push_back(it);
		if (func == FUNC_LOAD && !gen_loaded[sym]) begin
			gen_loaded[sym] = 1'b1;
			gen_syms.push_back(sym);
		end
	endtask

	// Mostly encodes of loaded symbols, with fresh loads, flushes and some noise.
	task automatic queue_random_items(input int count);
		int done;
		int pick;
		int len_pick;
		logic [5:0] len;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 15 || gen_syms.size() == 0) begin
				len_pick = $urandom_range(0, 99);
				if (len_pick < 5)
					len = 6'd0;
				else if (len_pick < 10)
					len = 6'($urandom_range(33, 63));
				else if (len_pick < 25)
					len = 6'($urandom_range(13, 32));
				else
					len = 6'($urandom_range(1, 12));
				add_item(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom, len);
				done++;
			end else if (pick < 85) begin
				add_item(FUNC_ENCODE, gen_syms[$urandom_range(0, gen_syms.size() - 1)],
					$urandom, 6'($urandom_range(0, 63)));
				done++;
			end else if (pick < 95) begin
				add_item(FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom,
					6'($urandom_range(0, 63)));
				done++;
			end else begin
				add_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), $urandom,
					6'($urandom_range(0, 63)));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_ch.valid || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Input driver: presents the next queued transaction at the falling edge.
	always @(negedge clk) begin : drive_items
		packer_item_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_taken) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.func <= nxt.func;
				item_ch.symbol <= nxt.symbol;
				item_ch.code_value <= nxt.code_value;
				item_ch.code_length <= nxt.code_length;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
		byte_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: checks each output transaction, then predicts from the input one.
	always @(posedge clk) begin : observe
		packed_out_t want;
		packer_item_t seen;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				checked_bytes++;
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte 0x%02h last %0b",
						byte_ch.packed_byte, byte_ch.last));
				end else begin
					want = expected_bytes.pop_front();
					if (byte_ch.packed_byte !== want.packed_byte)
						report_mismatch($sformatf("packed_byte 0x%02h, expected 0x%02h",
							byte_ch.packed_byte, want.packed_byte));
					if (byte_ch.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b on byte 0x%02h",
							byte_ch.last, want.last, want.packed_byte));
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				seen.func = item_ch.func;
				seen.symbol = item_ch.symbol;
				seen.code_value = item_ch.code_value;
				seen.code_length = item_ch.code_length;
				predict_packed_bytes(seen);
			end
			item_taken <= item_ch.valid && item_ch.ready;
		end
	end

	// Watchdog: ends a run in which no transaction moves for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Main sequence: reset, directed items, then random items in idling phases.
	initial begin
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_LOAD;
		item_ch.symbol = '0;
		item_ch.code_value = '0;
		item_ch.code_length = '0;
		byte_ch.ready = 1'b0;
		item_taken = 1'b0;
		quiet_cycles = 0;
		pend_bits = '0;
		pend_cnt = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		load_count = 0;
		encode_count = 0;
		flush_count = 0;
		checked_bytes = 0;
		foreach (gen_loaded[i])
			gen_loaded[i] = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty flush, the unused function code, code length
		// extremes, stray code bits, a saturated long code, a zero-length code,
		// aligned and unaligned long codes and a padded flush.
		add_item(FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
		add_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		add_item(FUNC_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1);
		add_item(FUNC_LOAD, 8'hFF, 32'hA5C3_0F96, 6'd32);
		add_item(FUNC_LOAD, 8'h80, 32'h5A5A_5A5A, 6'd63);
		add_item(FUNC_LOAD, 8'h7F, 32'hFFFF_FFFF, 6'd0);
		add_item(FUNC_LOAD, 8'h01, 32'hFFFF_FF55, 6'd7);
		add_item(FUNC_LOAD, 8'h55, 32'h0000_00F0, 6'd8);
		add_item(FUNC_LOAD, 8'hAA, 32'h0000_01FF, 6'd9);
		add_item(FUNC_LOAD, 8'h3C, 32'h0000_0000, 6'd33);
		add_item(FUNC_ENCODE, 8'h00, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'h01, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'h00, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'h80, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'h7F, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'h55, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'hAA, 32'h0, 6'd0);
		add_item(FUNC_ENCODE, 8'h3C, 32'h0, 6'd0);
		add_item(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		add_item(FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
		wait_drained();

		// Random part over the idling phases, ending with a phase of none.
		queue_random_items(PHASE_ITEMS);
		wait_drained();
		send_idle_pct = 75;
		queue_random_items(PHASE_ITEMS);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 75;
		queue_random_items(PHASE_ITEMS);
		wait_drained();
		send_idle_pct = 30;
		recv_stall_pct = 30;
		queue_random_items(PHASE_ITEMS);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_items(PHASE_ITEMS);
		wait_drained();

		// Leave room for any stray byte to show up.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d table loads, %0d encodes and %0d flushes; %0d packed bytes checked.",
			load_count, encode_count, flush_count, checked_bytes);
		$display("Ran with no idling, idle sender, stalling receiver and both at once.");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### huffman_code_bit_packer.f
hdl/hcbp_pkg.sv
hdl/hcbp_item_if.sv
hdl/hcbp_result_if.sv
hdl/hcbp_datapath.sv
hdl/hcbp_controller.sv
hdl/huffman_code_bit_packer.sv
hdl/hcbp_checker.sv
test/huffman_code_bit_packer_tb.sv
